// File: design/srsw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srsw_pkg
// Shared types and constants of the selective repeat sender window.
// ----------------------------------------------------------------------------
package srsw_pkg;

    localparam int MAX_WINDOW = 64;
    localparam int SLOT_COUNT = 2 * MAX_WINDOW;
    localparam int SEQ_W      = $clog2(SLOT_COUNT);
    localparam int SPAN_W     = SEQ_W + 1;
    localparam int LAP_BITS   = 16;
    localparam int BYTE_W     = 32;
    localparam int CHUNK_W    = 16;
    localparam int WIN_W      = 7;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 2;
    localparam int CNT_W      = 7;

    localparam int IN_DATA_W  = 24;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 112;
    localparam int OUT_USER_W = 2;

    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_TRANSFER = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CHUNK    = 2'd2;

    localparam logic [WIN_W-1:0]   WINDOW_RESET = 7'd1;
    localparam logic [CHUNK_W-1:0] CHUNK_RESET  = 16'd1024;

    typedef enum logic {
        KIND_SEND = 1'b0,
        KIND_ACK  = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        ST_SENT    = 2'd0,
        ST_ACK_OK  = 2'd1,
        ST_ACK_IGN = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef struct packed {
        kind_t               kind;
        logic                is_data;
        logic [SEQ_W-1:0]    ack_seq;
        logic [LAP_BITS-1:0] ack_lap;
    } item_t;

    typedef struct packed {
        logic                is_data;
        logic [LAP_BITS-1:0] lap;
    } slot_word_t;

endpackage : srsw_pkg
`default_nettype wire

// File: design/srsw_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srsw_front
// Accepts input beats, decodes them into work items and queues them.
// ----------------------------------------------------------------------------
module srsw_front
    import srsw_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // ack_seq, ack_lap
    input  wire logic [IN_USER_W-1:0]  s_tuser,   // op, is_data
    output logic                       q_valid,
    input  wire logic                  q_ready,
    output item_t                      q_item
);

    item_t                q_mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg, count_next;
    item_t                in_item;
    logic                 push, pop;

    always_comb begin
        in_item.kind    = s_tuser[0] ? KIND_ACK : KIND_SEND;
        in_item.is_data = s_tuser[1];
        in_item.ack_seq = s_tdata[SEQ_W-1:0];
        in_item.ack_lap = s_tdata[SEQ_W +: LAP_BITS];
    end

    assign s_tready = (count_reg != Q_CNT_W'(Q_DEPTH)) || (s_tdata[IN_DATA_W-1] && 1'b0);
    assign q_valid  = (count_reg != '0);
    assign q_item   = q_mem_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule : srsw_front
`default_nettype wire

// File: design/srsw_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srsw_back
// Window sequencer: slot store, counters, base walk and result register.
// ----------------------------------------------------------------------------
module srsw_back
    import srsw_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                   q_valid,
    output logic                        q_ready,
    input  wire item_t                  q_item,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_DATA_W-1:0]       m_tdata,
    output logic [OUT_USER_W-1:0]       m_tuser
);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_NORM = 9'b000000010,
        S_SRD  = 9'b000000100,
        S_SADD = 9'b000001000,
        S_ARD  = 9'b000010000,
        S_WALK = 9'b000100000,
        S_WRD  = 9'b001000000,
        S_WADD = 9'b010000000,
        S_OUT  = 9'b100000000
    } state_t;

    function automatic logic [BYTE_W-1:0] chunk_of(
        input logic [BYTE_W-1:0]  total,
        input logic [CHUNK_W-1:0] chunk,
        input logic [BYTE_W-1:0]  done
    );
        logic [BYTE_W-1:0] left;
        logic [BYTE_W-1:0] wide_chunk;
        left       = (total > done) ? (total - done) : '0;
        wide_chunk = BYTE_W'(chunk);
        return (left < wide_chunk) ? left : wide_chunk;
    endfunction

    state_t                 state_reg, state_next;
    logic [WIN_W-1:0]       window_reg;
    logic [BYTE_W-1:0]      transfer_reg;
    logic [CHUNK_W-1:0]     chunk_bytes_reg;

    item_t                  item_reg, item_next;
    logic [SEQ_W-1:0]       next_seq_reg, next_seq_next;
    logic [SEQ_W-1:0]       base_seq_reg, base_seq_next;
    logic [CNT_W-1:0]       flight_reg, flight_next;
    logic [BYTE_W-1:0]      sent_reg, sent_next;
    logic [BYTE_W-1:0]      conf_reg, conf_next;
    logic [BYTE_W-1:0]      step_reg, step_next;
    logic [SLOT_COUNT-1:0]  pending_reg, pending_next;
    logic [SLOT_COUNT-1:0]  acked_reg, acked_next;
    logic [SLOT_COUNT-1:0]  lap_vld_reg, lap_vld_next;
    status_t                status_reg, status_next;
    logic [SEQ_W-1:0]       oseq_reg, oseq_next;
    logic [LAP_BITS-1:0]    olap_reg, olap_next;
    logic [SPAN_W-1:0]      released_reg, released_next;

    logic                   m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0]  m_data_reg, m_data_next;
    logic [OUT_USER_W-1:0]  m_user_reg, m_user_next;

    slot_word_t             slot_mem [SLOT_COUNT];
    slot_word_t             rd_data_reg;
    logic                   rd_en, wr_en;
    logic [SEQ_W-1:0]       rd_addr;
    slot_word_t             wr_data;

    logic [WIN_W-1:0]       eff_w;
    logic [SPAN_W-1:0]      span;
    logic [LAP_BITS-1:0]    rd_lap;
    logic [LAP_BITS-1:0]    new_lap;
    logic [SEQ_W-1:0]       seq_inc;
    logic [SEQ_W-1:0]       base_inc;

    always_comb begin
        if (window_reg == '0) begin
            eff_w = WIN_W'(1);
        end else if (window_reg > WIN_W'(MAX_WINDOW)) begin
            eff_w = WIN_W'(MAX_WINDOW);
        end else begin
            eff_w = window_reg;
        end
        span     = {eff_w, 1'b0};
        seq_inc  = ((SPAN_W'(next_seq_reg) + 1'b1) == span) ? '0 : next_seq_reg + 1'b1;
        base_inc = ((SPAN_W'(base_seq_reg) + 1'b1) == span) ? '0 : base_seq_reg + 1'b1;
    end

    always_comb begin
        state_next    = state_reg;
        item_next     = item_reg;
        next_seq_next = next_seq_reg;
        base_seq_next = base_seq_reg;
        flight_next   = flight_reg;
        sent_next     = sent_reg;
        conf_next     = conf_reg;
        step_next     = step_reg;
        pending_next  = pending_reg;
        acked_next    = acked_reg;
        lap_vld_next  = lap_vld_reg;
        status_next   = status_reg;
        oseq_next     = oseq_reg;
        olap_next     = olap_reg;
        released_next = released_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        m_user_next   = m_user_reg;
        q_ready       = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = next_seq_reg;
        wr_en         = 1'b0;
        wr_data       = '0;
        rd_lap        = '0;
        new_lap       = '0;

        unique case (state_reg)
            S_IDLE: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    item_next     = q_item;
                    oseq_next     = '0;
                    olap_next     = '0;
                    released_next = '0;
                    state_next    = S_NORM;
                end
            end
            S_NORM: begin
                if (SPAN_W'(next_seq_reg) >= span) begin
                    next_seq_next = SEQ_W'(SPAN_W'(next_seq_reg) - span);
                end else if (SPAN_W'(base_seq_reg) >= span) begin
                    base_seq_next = SEQ_W'(SPAN_W'(base_seq_reg) - span);
                end else if (item_reg.kind == KIND_SEND) begin
                    if (flight_reg >= eff_w) begin
                        status_next = ST_FULL;
                        state_next  = S_OUT;
                    end else begin
                        rd_en      = 1'b1;
                        rd_addr    = next_seq_reg;
                        state_next = S_SRD;
                    end
                end else begin
                    if ((SPAN_W'(item_reg.ack_seq) >= span) ||
                        !pending_reg[item_reg.ack_seq]) begin
                        status_next = ST_ACK_IGN;
                        state_next  = S_OUT;
                    end else begin
                        rd_en      = 1'b1;
                        rd_addr    = item_reg.ack_seq;
                        state_next = S_ARD;
                    end
                end
            end
            S_SRD: begin
                rd_lap  = lap_vld_reg[next_seq_reg] ? rd_data_reg.lap : '0;
                new_lap = rd_lap + 1'b1;
                wr_en   = 1'b1;
                wr_data.is_data = item_reg.is_data;
                wr_data.lap     = new_lap;
                lap_vld_next[next_seq_reg] = 1'b1;
                pending_next[next_seq_reg] = 1'b1;
                acked_next[next_seq_reg]   = 1'b0;
                step_next     = chunk_of(transfer_reg, chunk_bytes_reg, sent_reg);
                flight_next   = flight_reg + 1'b1;
                next_seq_next = seq_inc;
                oseq_next     = next_seq_reg;
                olap_next     = new_lap;
                status_next   = ST_SENT;
                state_next    = item_reg.is_data ? S_SADD : S_OUT;
            end
            S_SADD: begin
                sent_next  = sent_reg + step_reg;
                state_next = S_OUT;
            end
            S_ARD: begin
                rd_lap = lap_vld_reg[item_reg.ack_seq] ? rd_data_reg.lap : '0;
                if (rd_lap != item_reg.ack_lap) begin
                    status_next = ST_ACK_IGN;
                    state_next  = S_OUT;
                end else begin
                    pending_next[item_reg.ack_seq] = 1'b0;
                    acked_next[item_reg.ack_seq]   = 1'b1;
                    status_next = ST_ACK_OK;
                    state_next  = (item_reg.ack_seq == base_seq_reg) ? S_WALK : S_OUT;
                end
            end
            S_WALK: begin
                if ((released_reg < span) && acked_reg[base_seq_reg]) begin
                    rd_en      = 1'b1;
                    rd_addr    = base_seq_reg;
                    state_next = S_WRD;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_WRD: begin
                acked_next[base_seq_reg]   = 1'b0;
                pending_next[base_seq_reg] = 1'b0;
                base_seq_next = base_inc;
                flight_next   = (flight_reg != '0) ? flight_reg - 1'b1 : '0;
                released_next = released_reg + 1'b1;
                step_next     = chunk_of(transfer_reg, chunk_bytes_reg, conf_reg);
                state_next    = rd_data_reg.is_data ? S_WADD : S_WALK;
            end
            S_WADD: begin
                conf_next  = conf_reg + step_reg;
                state_next = S_WALK;
            end
            S_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_user_next  = status_reg;
                    m_data_next  = {4'b0, conf_reg, sent_reg, flight_reg, base_seq_reg,
                                    CNT_W'(released_reg), olap_reg, oseq_reg};
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            window_reg      <= WINDOW_RESET;
            transfer_reg    <= '0;
            chunk_bytes_reg <= CHUNK_RESET;
            next_seq_reg    <= '0;
            base_seq_reg    <= '0;
            flight_reg      <= '0;
            sent_reg        <= '0;
            conf_reg        <= '0;
            pending_reg     <= '0;
            acked_reg       <= '0;
            lap_vld_reg     <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            next_seq_reg <= next_seq_next;
            base_seq_reg <= base_seq_next;
            flight_reg   <= flight_next;
            sent_reg     <= sent_next;
            conf_reg     <= conf_next;
            pending_reg  <= pending_next;
            acked_reg    <= acked_next;
            lap_vld_reg  <= lap_vld_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_we) begin
                case (cfg_addr)
                    REG_WINDOW:   window_reg      <= cfg_wdata[WIN_W-1:0];
                    REG_TRANSFER: transfer_reg    <= cfg_wdata[BYTE_W-1:0];
                    REG_CHUNK:    chunk_bytes_reg <= cfg_wdata[CHUNK_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        step_reg     <= step_next;
        status_reg   <= status_next;
        oseq_reg     <= oseq_next;
        olap_reg     <= olap_next;
        released_reg <= released_next;
        m_data_reg   <= m_data_next;
        m_user_reg   <= m_user_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_mem[next_seq_reg] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule : srsw_back
`default_nettype wire

// File: design/selective_repeat_sender_window.sv
`default_nettype none
// ----------------------------------------------------------------------------
// selective_repeat_sender_window
// Sender-side selective repeat window: sequence numbering, ack tracking and
// in-order window advance with byte accounting.
// ----------------------------------------------------------------------------
// Input beats (s_*) carry a send request or a received ack; each produces
// exactly one result beat (m_*) with the status and the window counters after
// the step. Window size, transfer length and chunk size are set through the
// cfg_* write port while the block is idle; the block does not enforce this.
// A two-entry queue decouples the input side from the window sequencer, so
// beats are taken while a result waits in the output register.
// Items are processed one at a time by the sequencer with a one-port slot
// store (registered read). A send reads its slot and writes the new lap; a
// data packet also adds its chunk to bytes sent. A full window refuses it.
// An ack reads its slot and checks the lap; an accepted ack of the window
// base then retires acked slots in order, adding a chunk per data slot.
// After a window change, out-of-span sequence pointers are reduced first.
// Reset clears every slot to retired, zeroes the window counters and loads the
// register defaults; no clearing pass is needed.
// While m_tready is low the finished result holds; the queue keeps taking
// beats until it fills, then s_tready drops.
// ----------------------------------------------------------------------------
module selective_repeat_sender_window
    import srsw_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_DATA_W-1:0]   s_tdata,   // ack_seq, ack_lap
    input  wire logic [IN_USER_W-1:0]   s_tuser,   // op, is_data
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // seq, lap, released, window_base, in_flight, bytes_sent, bytes_confirmed
    output logic [OUT_DATA_W-1:0]       m_tdata,
    output logic [OUT_USER_W-1:0]       m_tuser    // status
);

    logic  q_valid;
    logic  q_ready;
    item_t q_item;

    srsw_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    srsw_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule : selective_repeat_sender_window
`default_nettype wire

// File: bench/tb_selective_repeat_sender_window.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_selective_repeat_sender_window
// Self-checking bench for the selective repeat sender window. A directed
// table covers reset state, full window refusal, stale and duplicate acks,
// out-of-order acks, byte saturation and out-of-range window values. Random
// phases follow, each with new window, transfer and chunk settings, made
// mostly of sends and acks of pending slots with some noise mixed in. The
// input side works in bursts, the output side stalls on its own pattern, and
// every result beat is checked against the window model or a typed result.
// ----------------------------------------------------------------------------
module tb_selective_repeat_sender_window;
    import srsw_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int LIMIT_CYC   = 3_000_000;
    localparam int SETTLE_CYC  = 8;
    localparam int DRAIN_CYC   = 600;
    localparam int HOLD_CYC    = 300;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 110;
    localparam int MAX_REPORT  = 10;

    localparam logic [1:0] MARK_PENDING = 2'd0;
    localparam logic [1:0] MARK_ACKED   = 2'd1;
    localparam logic [1:0] MARK_RETIRED = 2'd2;

    // m_tdata field offsets
    localparam int OFS_LAP  = SEQ_W;
    localparam int OFS_REL  = OFS_LAP + LAP_BITS;
    localparam int OFS_BASE = OFS_REL + CNT_W;
    localparam int OFS_FLT  = OFS_BASE + SEQ_W;
    localparam int OFS_SENT = OFS_FLT + CNT_W;
    localparam int OFS_CONF = OFS_SENT + BYTE_W;

    typedef struct packed {
        status_t             status;
        logic [SEQ_W-1:0]    seq;
        logic [LAP_BITS-1:0] lap;
        logic [CNT_W-1:0]    released;
        logic [SEQ_W-1:0]    base;
        logic [CNT_W-1:0]    flight;
        logic [BYTE_W-1:0]   sent;
        logic [BYTE_W-1:0]   conf;
    } win_result_t;

    typedef enum logic { ROW_BEAT, ROW_REG } row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [CFG_ADDR_W-1:0] reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        item_t                 beat;
        bit                    typed;
        win_result_t           want;
    } row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;   // ack_seq, ack_lap
    logic [IN_USER_W-1:0]  s_tuser;   // op, is_data
    logic                  m_tvalid;
    logic                  m_tready;
    // seq, lap, released, window_base, in_flight, bytes_sent, bytes_confirmed
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;   // status

    selective_repeat_sender_window uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // window model state
    logic [1:0]          mdl_mark [SLOT_COUNT];
    logic [LAP_BITS-1:0] mdl_lap  [SLOT_COUNT];
    logic                mdl_data [SLOT_COUNT];
    int unsigned         mdl_next;
    int unsigned         mdl_base;
    int unsigned         mdl_flight;
    logic [BYTE_W-1:0]   mdl_sent;
    logic [BYTE_W-1:0]   mdl_conf;
    logic [WIN_W-1:0]    cfg_window;
    logic [BYTE_W-1:0]   cfg_transfer;
    logic [CHUNK_W-1:0]  cfg_chunk;

    win_result_t step_results[$];
    int unsigned fail_cnt    = 0;
    int unsigned cycles      = 0;
    int unsigned hold_ticket = 0;
    int unsigned burst_left  = 0;

    initial begin
        aclk = 1'b0;
        forever #(CLK_HALF) aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYC) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic model_reset();
        for (int i = 0; i < SLOT_COUNT; i++) begin
            mdl_mark[i] = MARK_RETIRED;
            mdl_lap[i]  = '0;
            mdl_data[i] = 1'b0;
        end
        mdl_next     = 0;
        mdl_base     = 0;
        mdl_flight   = 0;
        mdl_sent     = '0;
        mdl_conf     = '0;
        cfg_window   = WINDOW_RESET;
        cfg_transfer = '0;
        cfg_chunk    = CHUNK_RESET;
    endtask

    function automatic int unsigned win_size();
        if (cfg_window == 0) return 1;
        if (cfg_window > MAX_WINDOW) return MAX_WINDOW;
        return cfg_window;
    endfunction

    // bytes carried by the next data packet, saturating at the transfer end
    function automatic logic [BYTE_W-1:0] chunk_take(logic [BYTE_W-1:0] done);
        logic [BYTE_W-1:0] left;
        left = (cfg_transfer > done) ? cfg_transfer - done : '0;
        return (left < BYTE_W'(cfg_chunk)) ? left : BYTE_W'(cfg_chunk);
    endfunction

    task automatic window_step(input item_t it, output win_result_t r);
        int unsigned      w;
        int unsigned      span;
        int unsigned      n;
        logic [SEQ_W-1:0] s;
        w    = win_size();
        span = 2 * w;
        mdl_next = mdl_next % span;
        mdl_base = mdl_base % span;
        r = '0;
        if (it.kind == KIND_SEND) begin
            if (mdl_flight >= w) begin
                r.status = ST_FULL;
            end else begin
                s = SEQ_W'(mdl_next);
                mdl_mark[s] = MARK_PENDING;
                mdl_data[s] = it.is_data;
                mdl_lap[s]  = mdl_lap[s] + 1'b1;
                if (it.is_data) mdl_sent = mdl_sent + chunk_take(mdl_sent);
                r.seq      = s;
                r.lap      = mdl_lap[s];
                mdl_next   = (mdl_next + 1) % span;
                mdl_flight = mdl_flight + 1;
                r.status   = ST_SENT;
            end
        end else if (it.ack_seq >= span || mdl_lap[it.ack_seq] != it.ack_lap ||
                     mdl_mark[it.ack_seq] != MARK_PENDING) begin
            r.status = ST_ACK_IGN;
        end else begin
            mdl_mark[it.ack_seq] = MARK_ACKED;
            r.status = ST_ACK_OK;
            if (it.ack_seq == mdl_base) begin
                n = 0;
                while (n < span && mdl_mark[mdl_base] == MARK_ACKED) begin
                    if (mdl_data[mdl_base]) mdl_conf = mdl_conf + chunk_take(mdl_conf);
                    mdl_mark[mdl_base] = MARK_RETIRED;
                    mdl_base = (mdl_base + 1) % span;
                    if (mdl_flight > 0) mdl_flight = mdl_flight - 1;
                    n++;
                end
                r.released = CNT_W'(n);
            end
        end
        r.base   = SEQ_W'(mdl_base);
        r.flight = CNT_W'(mdl_flight);
        r.sent   = mdl_sent;
        r.conf   = mdl_conf;
    endtask

    // next random beat, drawn from the current window state
    function automatic item_t pick_beat();
        item_t            it;
        int unsigned      w;
        int unsigned      span;
        int unsigned      base;
        int unsigned      r;
        int               i;
        logic [SEQ_W-1:0] open_q[$];
        logic [SEQ_W-1:0] s;
        w    = win_size();
        span = 2 * w;
        base = mdl_base % span;
        for (i = 0; i < span; i++)
            if (mdl_mark[i] == MARK_PENDING) open_q.push_back(SEQ_W'(i));
        it.kind    = KIND_ACK;
        it.is_data = 1'($urandom_range(0, 1));
        it.ack_seq = SEQ_W'($urandom);
        it.ack_lap = LAP_BITS'($urandom);
        r = $urandom_range(0, 99);
        if (r < 45 && mdl_flight < w) begin
            it.kind    = KIND_SEND;
            it.is_data = ($urandom_range(0, 3) != 0);
        end else if (r < 88 && open_q.size() > 0) begin
            if (mdl_mark[base] == MARK_PENDING && $urandom_range(0, 1) == 1)
                s = SEQ_W'(base);
            else
                s = open_q[$urandom_range(0, open_q.size() - 1)];
            it.ack_seq = s;
            it.ack_lap = mdl_lap[s];
        end else begin
            s = SEQ_W'($urandom_range(0, span - 1));
            case ($urandom_range(0, 3))
                0: it.kind = kind_t'($urandom_range(0, 1));
                1: begin
                    it.ack_seq = s;
                    it.ack_lap = mdl_lap[s] - 1'b1;
                end
                2: begin
                    it.ack_seq = s;
                    it.ack_lap = mdl_lap[s];
                end
                default: it.kind = KIND_SEND;
            endcase
        end
        return it;
    endfunction

    task automatic send_beat(input item_t it, input bit typed, input win_result_t want);
        win_result_t r;
        bit          rdy;
        s_tvalid <= 1'b1;
        s_tdata  <= IN_DATA_W'({it.ack_lap, it.ack_seq});
        s_tuser  <= {it.is_data, it.kind};
        do begin
            @(negedge aclk);
            rdy = s_tready;
            @(posedge aclk);
        end while (!rdy);
        window_step(it, r);
        step_results.push_back(typed ? want : r);
    endtask

    task automatic after_beat();
        int unsigned gap;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic wait_drained();
        if (s_tvalid) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        while (step_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic reg_write(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_WINDOW:   cfg_window   = val[WIN_W-1:0];
            REG_TRANSFER: cfg_transfer = val[BYTE_W-1:0];
            REG_CHUNK:    cfg_chunk    = val[CHUNK_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    function automatic win_result_t res(status_t st, int unsigned seq, int unsigned lap,
                                        int unsigned rel, int unsigned base,
                                        int unsigned flight, int unsigned sent,
                                        int unsigned conf);
        win_result_t r;
        r.status   = st;
        r.seq      = SEQ_W'(seq);
        r.lap      = LAP_BITS'(lap);
        r.released = CNT_W'(rel);
        r.base     = SEQ_W'(base);
        r.flight   = CNT_W'(flight);
        r.sent     = BYTE_W'(sent);
        r.conf     = BYTE_W'(conf);
        return r;
    endfunction

    function automatic row_t beat_row(kind_t k, bit d, int unsigned seq, int unsigned lap);
        row_t row;
        row.kind         = ROW_BEAT;
        row.reg_idx      = '0;
        row.reg_val      = '0;
        row.beat.kind    = k;
        row.beat.is_data = d;
        row.beat.ack_seq = SEQ_W'(seq);
        row.beat.ack_lap = LAP_BITS'(lap);
        row.typed        = 1'b0;
        row.want         = '0;
        return row;
    endfunction

    function automatic row_t typed_row(kind_t k, bit d, int unsigned seq, int unsigned lap,
                                       win_result_t want);
        row_t row;
        row       = beat_row(k, d, seq, lap);
        row.typed = 1'b1;
        row.want  = want;
        return row;
    endfunction

    function automatic row_t reg_row(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        row_t row;
        row         = beat_row(KIND_SEND, 1'b0, 0, 0);
        row.kind    = ROW_REG;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    initial begin : rx_side
        int unsigned mode;
        int unsigned left;
        int unsigned seen;
        int unsigned tick;
        m_tready <= 1'b0;
        mode = 0;
        left = 0;
        seen = 0;
        tick = 0;
        forever begin
            @(posedge aclk);
            if (hold_ticket != seen) begin
                // long hold-off so the input queue fills
                seen = hold_ticket;
                m_tready <= 1'b0;
                repeat (HOLD_CYC - 1) @(posedge aclk);
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 2);
                    left = $urandom_range(20, 200);
                end
                left--;
                tick++;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= ((tick % 5) < 2);
                endcase
            end
        end
    end

    always @(negedge aclk) begin : rx_check
        win_result_t got;
        win_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status   = status_t'(m_tuser);
            got.seq      = m_tdata[OFS_LAP-1:0];
            got.lap      = m_tdata[OFS_LAP  +: LAP_BITS];
            got.released = m_tdata[OFS_REL  +: CNT_W];
            got.base     = m_tdata[OFS_BASE +: SEQ_W];
            got.flight   = m_tdata[OFS_FLT  +: CNT_W];
            got.sent     = m_tdata[OFS_SENT +: BYTE_W];
            got.conf     = m_tdata[OFS_CONF +: BYTE_W];
            if (step_results.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= MAX_REPORT)
                    $display("[%0t] result beat with nothing expected: status %0d", $time,
                             got.status);
            end else begin
                want = step_results.pop_front();
                if (got !== want) begin
                    fail_cnt++;
                    if (fail_cnt <= MAX_REPORT)
                        $display({"[%0t] mismatch (got/exp): status %0d/%0d seq %0d/%0d ",
                                  "lap %0d/%0d rel %0d/%0d base %0d/%0d flight %0d/%0d ",
                                  "sent %0d/%0d conf %0d/%0d"}, $time,
                                 got.status, want.status, got.seq, want.seq,
                                 got.lap, want.lap, got.released, want.released,
                                 got.base, want.base, got.flight, want.flight,
                                 got.sent, want.sent, got.conf, want.conf);
                end
            end
        end
    end

    initial begin : stim
        row_t        plan[$];
        win_result_t none;
        int unsigned p;
        int unsigned k;
        logic [CFG_DATA_W-1:0] v;
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_addr  <= '0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        none = '0;
        model_reset();

        // reset defaults: W=1, nothing to transfer
        plan.push_back(typed_row(KIND_SEND, 1, 0, 0, res(ST_SENT, 0, 1, 0, 0, 1, 0, 0)));
        plan.push_back(typed_row(KIND_SEND, 0, 0, 0, res(ST_FULL, 0, 0, 0, 0, 1, 0, 0)));
        plan.push_back(typed_row(KIND_ACK, 0, 5, 1, res(ST_ACK_IGN, 0, 0, 0, 0, 1, 0, 0)));
        plan.push_back(typed_row(KIND_ACK, 0, 0, 0, res(ST_ACK_IGN, 0, 0, 0, 0, 1, 0, 0)));
        plan.push_back(typed_row(KIND_ACK, 0, 0, 1, res(ST_ACK_OK, 0, 0, 1, 1, 0, 0, 0)));
        plan.push_back(typed_row(KIND_ACK, 0, 0, 1, res(ST_ACK_IGN, 0, 0, 0, 1, 0, 0, 0)));
        // widest window, transfer saturates on the fourth chunk
        plan.push_back(reg_row(REG_WINDOW, 64));
        plan.push_back(reg_row(REG_TRANSFER, 3000));
        plan.push_back(reg_row(REG_CHUNK, 1000));
        plan.push_back(beat_row(KIND_SEND, 1, 0, 0));
        plan.push_back(beat_row(KIND_SEND, 1, 0, 0));
        plan.push_back(beat_row(KIND_SEND, 1, 0, 0));
        plan.push_back(beat_row(KIND_SEND, 1, 0, 0));
        plan.push_back(beat_row(KIND_SEND, 0, 0, 0));
        plan.push_back(beat_row(KIND_ACK, 0, 3, 1));
        plan.push_back(beat_row(KIND_ACK, 0, 2, 1));
        plan.push_back(beat_row(KIND_ACK, 0, 1, 1));
        plan.push_back(beat_row(KIND_ACK, 1, 5, 1));
        plan.push_back(beat_row(KIND_ACK, 0, 4, 1));
        plan.push_back(beat_row(KIND_ACK, 1, 127, 16'hFFFF));
        plan.push_back(beat_row(KIND_ACK, 0, 0, 1));
        // window 0 behaves as 1, largest chunk
        plan.push_back(reg_row(REG_WINDOW, 0));
        plan.push_back(reg_row(REG_TRANSFER, 32'hFFFF_FFFF));
        plan.push_back(reg_row(REG_CHUNK, 65535));
        plan.push_back(beat_row(KIND_SEND, 1, 0, 0));
        plan.push_back(beat_row(KIND_SEND, 1, 0, 0));
        plan.push_back(beat_row(KIND_ACK, 0, 0, 2));
        // window above the maximum, smallest chunk
        plan.push_back(reg_row(REG_WINDOW, 127));
        plan.push_back(reg_row(REG_CHUNK, 1));
        plan.push_back(beat_row(KIND_SEND, 0, 0, 0));
        plan.push_back(beat_row(KIND_SEND, 1, 0, 0));
        plan.push_back(beat_row(KIND_ACK, 0, 2, 2));
        plan.push_back(beat_row(KIND_ACK, 0, 1, 2));

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_REG) begin
                wait_drained();
                reg_write(plan[i].reg_idx, plan[i].reg_val);
            end else begin
                send_beat(plan[i].beat, plan[i].typed, plan[i].want);
                after_beat();
            end
        end

        for (p = 0; p < PHASES; p++) begin
            wait_drained();
            case ($urandom_range(0, 9))
                0:       v = 0;
                1:       v = 1;
                2:       v = MAX_WINDOW;
                3:       v = 127;
                4:       v = $urandom_range(MAX_WINDOW + 1, 127);
                default: v = $urandom_range(1, MAX_WINDOW);
            endcase
            reg_write(REG_WINDOW, v);
            case ($urandom_range(0, 5))
                0:       v = 0;
                1:       v = 32'hFFFF_FFFF;
                2:       v = $urandom;
                default: v = $urandom_range(0, 200000);
            endcase
            reg_write(REG_TRANSFER, v);
            case ($urandom_range(0, 5))
                0:       v = 1;
                1:       v = 65535;
                2:       v = $urandom_range(1, 65535);
                default: v = $urandom_range(1, 4096);
            endcase
            reg_write(REG_CHUNK, v);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if (k == 40 && (p == 0 || $urandom_range(0, 3) == 0))
                    hold_ticket <= hold_ticket + 1;
                if (k == 80 && p == 1)
                    wait_drained();
                send_beat(pick_beat(), 1'b0, none);
                after_beat();
            end
        end

        wait_drained();
        repeat (DRAIN_CYC) @(posedge aclk);
        if (fail_cnt == 0 && step_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
